FILE: rtl/bicv_pkg.sv
// Shared types, constants and helper functions of the boot image CRC validator.
// No dependencies; every other file of the block imports this package.
package bicv_pkg;

    // Trailer length in bytes after the covered image
    localparam int unsigned DIGEST_BYTES = 4;
    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [31:0] COUNT_MAX    = 32'hFFFF_FFFF;
    localparam logic [8:0]  HDR_SIZE_MIN = 9'd8;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_HDR_OFFSET = 3'd0,
        CFG_HDR_SIZE   = 3'd1,
        CFG_HDR_MAGIC  = 3'd2,
        CFG_SRAM_BASE  = 3'd3,
        CFG_SRAM_SIZE  = 3'd4,
        CFG_FLASH_BASE = 3'd5,
        CFG_FLASH_SIZE = 3'd6
    } t_cfg_idx;

    // Failure codes, first failing check wins
    typedef enum logic [2:0] {
        FAIL_NONE      = 3'd0,
        FAIL_SHORT     = 3'd1,
        FAIL_MAGIC     = 3'd2,
        FAIL_LEN_SMALL = 3'd3,
        FAIL_LEN_LARGE = 3'd4,
        FAIL_DIGEST    = 3'd5,
        FAIL_VECTORS   = 3'd6
    } t_fail;

    typedef struct packed {
        logic [15:0] hdr_offset;
        logic [8:0]  hdr_size;
        logic [31:0] hdr_magic;
        logic [31:0] sram_base;
        logic [31:0] sram_size;
        logic [31:0] flash_base;
        logic [31:0] flash_size;
    } t_cfg;

    // Region state as it stands after the last byte
    typedef struct packed {
        logic [31:0] count;
        logic [31:0] crc;
        logic [31:0] stack_vec;
        logic [31:0] entry_vec;
        logic [31:0] magic;
        logic [31:0] length;
        logic [31:0] trailer;
    } t_snap;

    typedef struct packed {
        logic [31:0] digest;
        t_fail       reason;
        logic        image_ok;
    } t_result;

    // One byte of reflected CRC-32, bit at a time
    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Replace one little-endian byte lane of a word
    function automatic logic [31:0] put_le(input logic [31:0] word, input logic [1:0] lane,
                                           input logic [7:0] b);
        logic [31:0] w;
        w = word;
        case (lane)
            2'd0:    w[7:0]   = b;
            2'd1:    w[15:8]  = b;
            2'd2:    w[23:16] = b;
            default: w[31:24] = b;
        endcase
        return w;
    endfunction

endpackage

FILE: rtl/bicv_regs.sv
// Configuration register file of the boot image CRC validator.
// Depends on bicv_pkg for the register index codes and the t_cfg struct.
module bicv_regs
    import bicv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write index
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_HDR_OFFSET: n_cfg.hdr_offset = i_cfg_data[15:0];
                CFG_HDR_SIZE:   n_cfg.hdr_size   = i_cfg_data[8:0];
                CFG_HDR_MAGIC:  n_cfg.hdr_magic  = i_cfg_data;
                CFG_SRAM_BASE:  n_cfg.sram_base  = i_cfg_data;
                CFG_SRAM_SIZE:  n_cfg.sram_size  = i_cfg_data;
                CFG_FLASH_BASE: n_cfg.flash_base = i_cfg_data;
                CFG_FLASH_SIZE: n_cfg.flash_size = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    // Hold the registers, header size defaults to eight bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{hdr_size: HDR_SIZE_MIN, default: '0};
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/bicv_track.sv
// Per-byte region tracker: byte count, vector and header capture, CRC and trailer.
// Depends on bicv_pkg for crc_byte, put_le and the t_cfg / t_snap structs.
module bicv_track
    import bicv_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cfg       i_cfg,
    input  logic       i_fire,
    input  logic [7:0] i_byte,
    input  logic       i_last,
    output t_snap      o_snap
);

    logic [31:0] r_count, r_crc, r_stack, r_entry, r_magic, r_length, r_trailer;
    logic [31:0] n_count, n_crc, n_stack, n_entry, n_magic, n_length, n_trailer;
    logic        hdr_ge;
    logic [31:0] hdr_d;
    logic [31:0] tr_e;

    // Offsets of the current byte from the header and from the image end
    assign hdr_ge = r_count >= {16'd0, i_cfg.hdr_offset};
    assign hdr_d  = r_count - {16'd0, i_cfg.hdr_offset};
    assign tr_e   = r_count - r_length;

    // Fold one byte into the region state
    always_comb begin
        n_count   = r_count;
        n_crc     = r_crc;
        n_stack   = r_stack;
        n_entry   = r_entry;
        n_magic   = r_magic;
        n_length  = r_length;
        n_trailer = r_trailer;
        if (i_fire && (r_count != COUNT_MAX)) begin
            if (r_count < 32'd4) begin
                n_stack = put_le(r_stack, r_count[1:0], i_byte);
            end else if (r_count < 32'd8) begin
                n_entry = put_le(r_entry, r_count[1:0], i_byte);
            end
            if (hdr_ge && (hdr_d < 32'd4)) begin
                n_magic = put_le(r_magic, hdr_d[1:0], i_byte);
            end else if (hdr_ge && (hdr_d < 32'd8)) begin
                n_length = put_le(r_length, hdr_d[1:0], i_byte);
            end
            // Cover everything up to the end of the length word, then up to the length
            if (!hdr_ge || (hdr_d < 32'd8) || (r_count < r_length)) begin
                n_crc = crc_byte(r_crc, i_byte);
            end else if (tr_e < 32'(DIGEST_BYTES)) begin
                n_trailer = put_le(r_trailer, tr_e[1:0], i_byte);
            end
            n_count = r_count + 32'd1;
        end
    end

    // Advance the state, drop it back to reset after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_fire && i_last)) begin
            r_count   <= '0;
            r_crc     <= CRC_INIT;
            r_stack   <= '0;
            r_entry   <= '0;
            r_magic   <= '0;
            r_length  <= '0;
            r_trailer <= '0;
        end else begin
            r_count   <= n_count;
            r_crc     <= n_crc;
            r_stack   <= n_stack;
            r_entry   <= n_entry;
            r_magic   <= n_magic;
            r_length  <= n_length;
            r_trailer <= n_trailer;
        end
    end

    assign o_snap = '{count: n_count, crc: n_crc, stack_vec: n_stack, entry_vec: n_entry,
                      magic: n_magic, length: n_length, trailer: n_trailer};

`ifndef SYNTHESIS
    // A region always restarts from an empty count and a fresh CRC
    a_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && i_last) |=> (r_count == '0) && (r_crc == CRC_INIT))
        else $error("tracker did not restart after last byte");
    // The count moves by at most one per byte and only on a request
    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_fire) |=> $stable(r_count))
        else $error("byte count moved without a request");
`endif

endmodule

FILE: rtl/bicv_check.sv
// Final validity checks on a captured region state, priority ordered.
// Depends on bicv_pkg for t_cfg, t_snap, t_result and the failure codes.
module bicv_check
    import bicv_pkg::*;
(
    input  t_cfg    i_cfg,
    input  t_snap   i_snap,
    output t_result o_result
);

    logic [8:0]  eff_size;
    logic [16:0] hdr_end;
    logic [17:0] min_region;
    logic [32:0] region_lim;
    logic [32:0] sram_end;
    logic [32:0] flash_end;
    logic [31:0] digest;
    logic        sp_ok, pc_ok;
    t_fail       reason;

    assign eff_size   = (i_cfg.hdr_size < HDR_SIZE_MIN) ? HDR_SIZE_MIN : i_cfg.hdr_size;
    assign hdr_end    = {1'b0, i_cfg.hdr_offset} + {8'd0, eff_size};
    assign min_region = {1'b0, hdr_end} + 18'(DIGEST_BYTES);
    assign region_lim = {1'b0, i_snap.count} - 33'(DIGEST_BYTES);
    assign digest     = ~i_snap.crc;

    // Vector windows, 33-bit sums
    assign sram_end  = {1'b0, i_cfg.sram_base} + {1'b0, i_cfg.sram_size};
    assign flash_end = {1'b0, i_cfg.flash_base} + {1'b0, i_cfg.flash_size};
    assign sp_ok = (i_snap.stack_vec > i_cfg.sram_base)
                && ({1'b0, i_snap.stack_vec} <= sram_end)
                && (i_snap.stack_vec[2:0] == 3'd0);
    assign pc_ok = (i_snap.entry_vec >= i_cfg.flash_base)
                && ({1'b0, i_snap.entry_vec} < flash_end)
                && i_snap.entry_vec[0];

    // First failing check wins
    always_comb begin
        if ({1'b0, i_snap.count} < {15'd0, min_region}) begin
            reason = FAIL_SHORT;
        end else if (i_snap.magic != i_cfg.hdr_magic) begin
            reason = FAIL_MAGIC;
        end else if (i_snap.length < {15'd0, hdr_end}) begin
            reason = FAIL_LEN_SMALL;
        end else if ({1'b0, i_snap.length} > region_lim) begin
            reason = FAIL_LEN_LARGE;
        end else if (i_snap.trailer != digest) begin
            reason = FAIL_DIGEST;
        end else if (!(sp_ok && pc_ok)) begin
            reason = FAIL_VECTORS;
        end else begin
            reason = FAIL_NONE;
        end
    end

    assign o_result = '{digest: digest, reason: reason, image_ok: (reason == FAIL_NONE)};

endmodule

FILE: rtl/boot_image_crc_validator_core.sv
// Boot image CRC validator. Takes one flash byte per cycle with no gaps needed: each
// request is folded into the byte count, vector/header capture and a byte-wide
// reflected CRC-32 update, which sets the rate at one byte per clock while not stalled.
// On the byte marked tlast the region state is captured in the snapshot register, then
// checked and placed in the output register once that register is free; the next region
// may start on the very next cycle. The input side stalls only while both the snapshot
// and the output register are full. There is no memory and no clearing pass after
// reset. Configuration writes are taken at once.
// Depends on bicv_pkg, bicv_regs, bicv_track and bicv_check.
module boot_image_crc_validator_core
    import bicv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    // Byte stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
    input  logic        s_axis_tlast,   // last_byte
    // Verdict out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata    // [0] image_ok, [3:1] fail_reason,
                                        // [35:4] computed_digest, [39:36] zero
);

    t_cfg    cfg;
    t_snap   track_snap;
    t_result check_res;

    t_snap   r_snap;
    logic    r_snap_valid;
    t_result r_out;
    logic    r_out_valid;

    logic    out_free;
    logic    snap_free;
    logic    s_fire;

    bicv_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: a slot is free when empty or when it drains this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign snap_free     = !r_snap_valid || out_free;
    assign s_axis_tready = snap_free;
    assign s_fire        = s_axis_tvalid && snap_free;

    bicv_track u_track (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (s_fire),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_snap  (track_snap)
    );

    bicv_check u_check (
        .i_cfg    (cfg),
        .i_snap   (r_snap),
        .o_result (check_res)
    );

    // Capture the region state on the last byte
    always_ff @(posedge i_clk) begin
        if (s_fire && s_axis_tlast) begin
            r_snap <= track_snap;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_snap_valid <= 1'b0;
        end else if (s_fire && s_axis_tlast) begin
            r_snap_valid <= 1'b1;
        end else if (out_free) begin
            r_snap_valid <= 1'b0;
        end
    end

    // Load the verdict into the output register
    always_ff @(posedge i_clk) begin
        if (r_snap_valid && out_free) begin
            r_out <= check_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_snap_valid;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'd0, r_out.digest, r_out.reason, r_out.image_ok};

`ifndef SYNTHESIS
    // Every last-byte request leaves a pending snapshot
    a_last_snap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tlast) |=> r_snap_valid)
        else $error("last byte did not produce a snapshot");
    // A blocked snapshot is neither lost nor overwritten
    a_snap_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_snap_valid && !out_free) |=> (r_snap_valid && $stable(r_snap)))
        else $error("pending snapshot lost or overwritten");
    // Pass flag agrees with the failure code
    a_ok_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.image_ok == (r_out.reason == FAIL_NONE)))
        else $error("image_ok disagrees with fail_reason");
`endif

endmodule
